/* hw/rtl/nctrk_pkg.sv */
`default_nettype none

package nctrk_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET_Y = 1'd1;

    // corner order inside a packed box
    localparam int BOX_MIN_X = 0;
    localparam int BOX_MIN_Y = 1;
    localparam int BOX_MAX_X = 2;
    localparam int BOX_MAX_Y = 3;

    // results that may be outstanding between input and output
    localparam int RESULT_DEPTH = 8;
    localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);
    localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);

    typedef struct packed {
        logic close;
        logic frame_end;
    } event_t;

endpackage

`default_nettype wire

/* hw/rtl/nctrk_accum.sv */
`default_nettype none

module nctrk_accum
    import nctrk_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_accept,
    input  wire logic [COORD_BITS-1:0]      point_x,
    input  wire logic [COORD_BITS-1:0]      point_y,
    input  wire logic                       contour_last,
    input  wire logic                       frame_last,
    input  wire logic                       no_contours,
    input  wire logic [COORD_BITS-1:0]      ref_x,
    input  wire logic [COORD_BITS-1:0]      ref_y,
    output event_t                          ev,
    output logic [3:0][COORD_BITS-1:0]      box,
    output logic [COORD_BITS-1:0]           pos_x,
    output logic [COORD_BITS-1:0]           pos_y
);

    logic [3:0][COORD_BITS-1:0] cur_box_reg, cur_box_next;
    logic [COORD_BITS-1:0]      ref_x_reg, ref_x_next;
    logic [COORD_BITS-1:0]      ref_y_reg, ref_y_next;
    logic                       at_frame_start_reg;
    logic                       at_contour_start_reg;
    logic                       open_after;
    event_t                     ev_next;
    event_t                     ev_reg;
    logic [3:0][COORD_BITS-1:0] box_reg;
    logic [COORD_BITS-1:0]      pos_x_reg, pos_y_reg;

    always_comb
    begin
        cur_box_next = cur_box_reg;
        ref_x_next   = at_frame_start_reg ? ref_x : ref_x_reg;
        ref_y_next   = at_frame_start_reg ? ref_y : ref_y_reg;
        open_after   = !at_contour_start_reg;
        if (!no_contours)
        begin
            if (at_contour_start_reg)
            begin
                cur_box_next[BOX_MIN_X] = point_x;
                cur_box_next[BOX_MIN_Y] = point_y;
                cur_box_next[BOX_MAX_X] = point_x;
                cur_box_next[BOX_MAX_Y] = point_y;
            end
            else
            begin
                if (point_x < cur_box_reg[BOX_MIN_X])
                    cur_box_next[BOX_MIN_X] = point_x;
                if (point_y < cur_box_reg[BOX_MIN_Y])
                    cur_box_next[BOX_MIN_Y] = point_y;
                if (point_x > cur_box_reg[BOX_MAX_X])
                    cur_box_next[BOX_MAX_X] = point_x;
                if (point_y > cur_box_reg[BOX_MAX_Y])
                    cur_box_next[BOX_MAX_Y] = point_y;
            end
            open_after = !contour_last;
        end
        // a contour left open at frame end is closed with the frame
        ev_next.close     = (!no_contours && contour_last) || (frame_last && open_after);
        ev_next.frame_end = frame_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_frame_start_reg   <= 1'b1;
            at_contour_start_reg <= 1'b1;
            ev_reg               <= '0;
        end
        else
        begin
            ev_reg <= in_accept ? ev_next : '0;
            if (in_accept)
            begin
                at_frame_start_reg   <= frame_last;
                at_contour_start_reg <= frame_last || !open_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cur_box_reg <= cur_box_next;
            ref_x_reg   <= ref_x_next;
            ref_y_reg   <= ref_y_next;
            box_reg     <= cur_box_next;
            pos_x_reg   <= ref_x_next;
            pos_y_reg   <= ref_y_next;
        end
    end

    assign ev    = ev_reg;
    assign box   = box_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;

endmodule

`default_nettype wire

/* hw/rtl/nctrk_dist.sv */
`default_nettype none

module nctrk_dist
    import nctrk_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  event_t                          in_ev,
    input  wire logic [3:0][COORD_BITS-1:0] in_box,
    input  wire logic [COORD_BITS-1:0]      pos_x,
    input  wire logic [COORD_BITS-1:0]      pos_y,
    output event_t                          ev,
    output logic [3:0][COORD_BITS-1:0]      box,
    output logic [COORD_BITS-1:0]           cx,
    output logic [COORD_BITS-1:0]           cy,
    output logic [COORD_BITS-1:0]           dx,
    output logic [COORD_BITS-1:0]           dy,
    output logic [2*COORD_BITS-1:0]         dx2,
    output logic [2*COORD_BITS-1:0]         dy2
);

    localparam int CW   = COORD_BITS + 1;
    localparam int SQ_W = 2 * COORD_BITS;

    function automatic logic [COORD_BITS-1:0] centre(input logic [COORD_BITS-1:0] lo,
                                                     input logic [COORD_BITS-1:0] hi);
        logic [CW-1:0] span;
        logic [CW-1:0] sum;
        span = CW'(hi) - CW'(lo) + CW'(1);
        sum  = CW'(lo) + (span >> 1);
        return sum[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    logic [COORD_BITS-1:0]      cx_next, cy_next;
    event_t                     ev1_reg, ev2_reg;
    logic [3:0][COORD_BITS-1:0] box1_reg, box2_reg;
    logic [COORD_BITS-1:0]      cx1_reg, cy1_reg, cx2_reg, cy2_reg;
    logic [COORD_BITS-1:0]      dx1_reg, dy1_reg, dx2_d_reg, dy2_d_reg;
    logic [SQ_W-1:0]            dx_sq_reg, dy_sq_reg;

    assign cx_next = centre(in_box[BOX_MIN_X], in_box[BOX_MAX_X]);
    assign cy_next = centre(in_box[BOX_MIN_Y], in_box[BOX_MAX_Y]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev1_reg <= '0;
            ev2_reg <= '0;
        end
        else
        begin
            ev1_reg <= in_ev;
            ev2_reg <= ev1_reg;
        end
    end

    // centre and offset, then squares
    always_ff @(posedge clk)
    begin
        box1_reg  <= in_box;
        cx1_reg   <= cx_next;
        cy1_reg   <= cy_next;
        dx1_reg   <= abs_diff(cx_next, pos_x);
        dy1_reg   <= abs_diff(cy_next, pos_y);
        box2_reg  <= box1_reg;
        cx2_reg   <= cx1_reg;
        cy2_reg   <= cy1_reg;
        dx2_d_reg <= dx1_reg;
        dy2_d_reg <= dy1_reg;
        dx_sq_reg <= SQ_W'(dx1_reg) * SQ_W'(dx1_reg);
        dy_sq_reg <= SQ_W'(dy1_reg) * SQ_W'(dy1_reg);
    end

    assign ev  = ev2_reg;
    assign box = box2_reg;
    assign cx  = cx2_reg;
    assign cy  = cy2_reg;
    assign dx  = dx2_d_reg;
    assign dy  = dy2_d_reg;
    assign dx2 = dx_sq_reg;
    assign dy2 = dy_sq_reg;

endmodule

`default_nettype wire

/* hw/rtl/nctrk_select.sv */
`default_nettype none

module nctrk_select
    import nctrk_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  event_t                          in_ev,
    input  wire logic [3:0][COORD_BITS-1:0] in_box,
    input  wire logic [COORD_BITS-1:0]      in_cx,
    input  wire logic [COORD_BITS-1:0]      in_cy,
    input  wire logic [COORD_BITS-1:0]      in_dx,
    input  wire logic [COORD_BITS-1:0]      in_dy,
    input  wire logic [2*COORD_BITS-1:0]    in_dx2,
    input  wire logic [2*COORD_BITS-1:0]    in_dy2,
    input  wire logic [COORD_BITS-1:0]      max_offset_x,
    input  wire logic [COORD_BITS-1:0]      max_offset_y,
    output logic                            res_valid,
    output logic                            res_detected,
    output logic [6*COORD_BITS-1:0]         res_data
);

    localparam int DIST_W = 2 * COORD_BITS + 1;

    logic [DIST_W-1:0]          sum_sq;
    logic                       take;
    logic [3:0][COORD_BITS-1:0] best_box_reg, best_box_next;
    logic [COORD_BITS-1:0]      best_cx_reg, best_cx_next;
    logic [COORD_BITS-1:0]      best_cy_reg, best_cy_next;
    logic [COORD_BITS-1:0]      best_dx_reg, best_dx_next;
    logic [COORD_BITS-1:0]      best_dy_reg, best_dy_next;
    logic [DIST_W-1:0]          best_dist_reg, best_dist_next;
    logic                       have_best_reg, have_best_next;

    logic                       out_valid_reg;
    logic                       out_have_reg;
    logic [3:0][COORD_BITS-1:0] out_box_reg;
    logic [COORD_BITS-1:0]      out_cx_reg, out_cy_reg, out_dx_reg, out_dy_reg;
    logic                       detected;

    assign sum_sq = DIST_W'(in_dx2) + DIST_W'(in_dy2);
    // strict compare keeps the earlier contour on a tie
    assign take = in_ev.close && (!have_best_reg || sum_sq < best_dist_reg);

    always_comb
    begin
        best_box_next  = take ? in_box : best_box_reg;
        best_cx_next   = take ? in_cx  : best_cx_reg;
        best_cy_next   = take ? in_cy  : best_cy_reg;
        best_dx_next   = take ? in_dx  : best_dx_reg;
        best_dy_next   = take ? in_dy  : best_dy_reg;
        best_dist_next = take ? sum_sq : best_dist_reg;
        have_best_next = have_best_reg || in_ev.close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
            best_dist_reg <= '1;
            out_valid_reg <= 1'b0;
            out_have_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_ev.frame_end;
            if (in_ev.frame_end)
            begin
                out_have_reg  <= have_best_next;
                have_best_reg <= 1'b0;
                best_dist_reg <= '1;
            end
            else
            begin
                have_best_reg <= have_best_next;
                best_dist_reg <= best_dist_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_box_reg <= best_box_next;
        best_cx_reg  <= best_cx_next;
        best_cy_reg  <= best_cy_next;
        best_dx_reg  <= best_dx_next;
        best_dy_reg  <= best_dy_next;
        if (in_ev.frame_end)
        begin
            out_box_reg <= best_box_next;
            out_cx_reg  <= best_cx_next;
            out_cy_reg  <= best_cy_next;
            out_dx_reg  <= best_dx_next;
            out_dy_reg  <= best_dy_next;
        end
    end

    // gate on the offset limits, fields read zero when nothing is found or it is out of limits
    assign detected = out_have_reg && (out_dx_reg <= max_offset_x)
                      && (out_dy_reg <= max_offset_y);

    assign res_valid    = out_valid_reg;
    assign res_detected = detected;
    assign res_data     = detected ? {out_cy_reg, out_cx_reg, out_box_reg} : '0;

endmodule

`default_nettype wire

/* hw/rtl/nctrk_outq.sv */
`default_nettype none

module nctrk_outq
    import nctrk_pkg::*;
#(
    parameter int DATA_W = 73
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              frame_in,
    output logic                   in_ready,
    input  wire logic              wr_valid,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0]       mem [RESULT_DEPTH];
    logic [RESULT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RESULT_CNT_W-1:0] count_reg, count_next;
    logic [RESULT_CNT_W-1:0] pending_reg, pending_next;
    logic                    rd_fire;

    assign rd_fire = rd_valid && rd_ready;

    always_comb
    begin
        count_next   = count_reg;
        pending_next = pending_reg;
        if (wr_valid && !rd_fire)
            count_next = count_reg + RESULT_CNT_W'(1);
        else if (!wr_valid && rd_fire)
            count_next = count_reg - RESULT_CNT_W'(1);
        // results in flight plus those queued, so a write always finds room
        if (frame_in && !rd_fire)
            pending_next = pending_reg + RESULT_CNT_W'(1);
        else if (!frame_in && rd_fire)
            pending_next = pending_reg - RESULT_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            if (wr_valid)
                wr_ptr_reg <= wr_ptr_reg + RESULT_PTR_W'(1);
            if (rd_fire)
                rd_ptr_reg <= rd_ptr_reg + RESULT_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign in_ready = (pending_reg != RESULT_CNT_W'(RESULT_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

endmodule

`default_nettype wire

/* hw/rtl/nearest_contour_gated_tracker.sv */
// nearest contour tracker
// the slave stream carries contour points, one item per cycle while tready is high;
// tlast marks the final item of a frame, tuser carries the contour-end and no-point
// flags, and the reference position is sampled from the first item of each frame
// per contour the running bounding box is kept; when a contour ends its box centre
// is scored by squared distance to the reference and the nearest one is held
// on every frame-end item one result item leaves on the master stream: the chosen
// box and centre in tdata, the detected flag in tuser
// throughput is one item per clock while tready is high; a result item shows after
// the frame-end item passes the bounding-box stage, the centre stage, the squaring stage,
// the nearest-contour compare and the write into the result queue
// results wait in an 8-entry queue; tready falls once 8 results are outstanding,
// so a stalled receiver only holds up input after that many frames
// max_offset_x/max_offset_y are written through the cfg port; the user must write
// them only while idle, which the block does not enforce; reset empties the queue,
// clears all frame state and sets both offset limits to all ones
`default_nettype none

module nearest_contour_gated_tracker
    import nctrk_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, ref_x, ref_y
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // contour_last, no_contours
    input  wire logic [1:0]                 s_axis_tuser,
    input  wire logic                       s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // box_min_x, box_min_y, box_max_x, box_max_y, center_x, center_y
    output logic [((6*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // detected
    output logic [0:0]                      m_axis_tuser,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [COORD_BITS-1:0]      cfg_wdata
);

    localparam int CB       = COORD_BITS;
    localparam int M_DATA_W = ((6*CB+7)/8)*8;
    localparam int RES_W    = 6*CB;

    logic                 in_accept;
    logic [CB-1:0]        max_offset_x_reg, max_offset_y_reg;

    event_t               a_ev;
    logic [3:0][CB-1:0]   a_box;
    logic [CB-1:0]        a_pos_x, a_pos_y;

    event_t               d_ev;
    logic [3:0][CB-1:0]   d_box;
    logic [CB-1:0]        d_cx, d_cy, d_dx, d_dy;
    logic [2*CB-1:0]      d_dx2, d_dy2;

    logic                 res_valid, res_detected;
    logic [RES_W-1:0]     res_data;
    logic [RES_W:0]       q_data;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_offset_x_reg <= '1;
            max_offset_y_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_OFFSET_X: max_offset_x_reg <= cfg_wdata;
                REG_MAX_OFFSET_Y: max_offset_y_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    nctrk_accum #(.COORD_BITS(CB)) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .point_x      (s_axis_tdata[CB-1:0]),
        .point_y      (s_axis_tdata[2*CB-1:CB]),
        .contour_last (s_axis_tuser[0]),
        .frame_last   (s_axis_tlast),
        .no_contours  (s_axis_tuser[1]),
        .ref_x        (s_axis_tdata[3*CB-1:2*CB]),
        .ref_y        (s_axis_tdata[4*CB-1:3*CB]),
        .ev           (a_ev),
        .box          (a_box),
        .pos_x        (a_pos_x),
        .pos_y        (a_pos_y)
    );

    nctrk_dist #(.COORD_BITS(CB)) u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ev  (a_ev),
        .in_box (a_box),
        .pos_x  (a_pos_x),
        .pos_y  (a_pos_y),
        .ev     (d_ev),
        .box    (d_box),
        .cx     (d_cx),
        .cy     (d_cy),
        .dx     (d_dx),
        .dy     (d_dy),
        .dx2    (d_dx2),
        .dy2    (d_dy2)
    );

    nctrk_select #(.COORD_BITS(CB)) u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ev        (d_ev),
        .in_box       (d_box),
        .in_cx        (d_cx),
        .in_cy        (d_cy),
        .in_dx        (d_dx),
        .in_dy        (d_dy),
        .in_dx2       (d_dx2),
        .in_dy2       (d_dy2),
        .max_offset_x (max_offset_x_reg),
        .max_offset_y (max_offset_y_reg),
        .res_valid    (res_valid),
        .res_detected (res_detected),
        .res_data     (res_data)
    );

    nctrk_outq #(.DATA_W(RES_W + 1)) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (in_accept && s_axis_tlast),
        .in_ready (s_axis_tready),
        .wr_valid (res_valid),
        .wr_data  ({res_detected, res_data}),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_data  (q_data)
    );

    assign m_axis_tdata    = M_DATA_W'(q_data[RES_W-1:0]);
    assign m_axis_tuser[0] = q_data[RES_W];

endmodule

`default_nettype wire
